>>> rtl/lcgdeal_pkg.sv
// lcgdeal_pkg: constants, state encoding and card decode helpers for the card dealer
// depends on nothing; imported by lcg_shuffle_card_dealer
package lcgdeal_pkg;

  localparam int DECK_SIZE     = 52;
  localparam int TEN_PILE_DEAL = 50;
  localparam int MAX_PILES     = 13;
  localparam int GAME_W        = 33;
  localparam int SEED_W        = 32;
  localparam int DRAW_W        = 17;
  localparam int CARD_W        = 6;
  localparam int ADDR_W        = 6;
  localparam int PILE_W        = 4;
  localparam int ROW_W         = 6;
  localparam int SUIT_W        = 2;
  localparam int RANK_W        = 4;
  localparam int BITCNT_W      = 5;

  localparam logic [SEED_W-1:0] LCG_MUL = 32'd214013;
  localparam logic [SEED_W-1:0] LCG_INC = 32'd2531011;

  localparam logic [PILE_W-1:0] PILES_RESET = 4'd8;
  localparam logic [PILE_W-1:0] PILES_MAX   = 4'(MAX_PILES);
  localparam logic [PILE_W-1:0] PILES_TEN   = 4'd10;

  localparam logic [CARD_W-1:0]   DECK_FULL   = 6'(DECK_SIZE);
  localparam logic [ROW_W-1:0]    LAST_INDEX  = 6'(DECK_SIZE - 1);
  localparam logic [ROW_W-1:0]    TEN_LAST    = 6'(TEN_PILE_DEAL - 1);
  localparam logic [BITCNT_W-1:0] DIV_LAST    = 5'(DRAW_W - 1);

  // sequencer states, one-hot
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_LCG  = 9'b000000010,
    S_DIV  = 9'b000000100,
    S_RDJ  = 9'b000001000,
    S_RDL  = 9'b000010000,
    S_WR   = 9'b000100000,
    S_T0   = 9'b001000000,
    S_T1   = 9'b010000000,
    S_T2   = 9'b100000000
  } state_t;

  // card value 1..52 to suit code: c mod 4 maps club, diamond, heart, spade
  function automatic logic [SUIT_W-1:0] card_suit(input logic [CARD_W-1:0] card);
    logic [CARD_W-1:0] c;
    logic [SUIT_W-1:0] s;
    c = card - 6'd1;
    case (c[1:0])
      2'd0:    s = 2'd1;
      2'd1:    s = 2'd0;
      2'd2:    s = 2'd2;
      default: s = 2'd3;
    endcase
    return s;
  endfunction

  function automatic logic [RANK_W-1:0] card_rank(input logic [CARD_W-1:0] card);
    logic [CARD_W-1:0] c;
    c = card - 6'd1;
    return RANK_W'(c[CARD_W-1:2]) + 4'd1;
  endfunction

  // draw value from the new seed; plus-one variant can reach 2^16
  function automatic logic [DRAW_W-1:0] draw_value(input logic [SEED_W-1:0] seed,
                                                   input logic plus_one,
                                                   input logic high_bit);
    logic [15:0] r;
    r = seed[31:16];
    if (plus_one) begin
      return {1'b0, r} + 17'd1;
    end
    return {1'b0, high_bit, r[14:0]};
  endfunction

endpackage

>>> rtl/lcg_shuffle_card_dealer.sv
// lcg_shuffle_card_dealer: numbered solitaire deal generator (lcg shuffle, swap-remove deck)
// depends on lcgdeal_pkg; holds the sequencer, serial remainder unit and 52-entry deck memory
//
// a game gives 52 card beats; the 17-step serial remainder (one bit a cycle) paces
//   each card, and ten-pile deals end with two temp cell beats after fifty dealt cards
// reset: synchronous active-high rst clears sequencer, strobe and deck valid bits, and
//   sets the pile count register to 8; the receiver cannot stall result beats
module lcg_shuffle_card_dealer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [lcgdeal_pkg::PILE_W-1:0]      cfg_wr_data,
  input  logic                                start,
  input  logic [lcgdeal_pkg::GAME_W-1:0]      game_number,
  output logic                                busy,
  output logic                                card_valid,
  output logic                                is_temp,
  output logic [lcgdeal_pkg::PILE_W-1:0]      pile,
  output logic [lcgdeal_pkg::ROW_W-1:0]       row,
  output logic [lcgdeal_pkg::SUIT_W-1:0]      suit,
  output logic [lcgdeal_pkg::RANK_W-1:0]      rank,
  output logic                                last
);
  import lcgdeal_pkg::*;

  state_t state;

  // configuration
  logic [PILE_W-1:0] num_piles;

  // per-deal control
  logic [PILE_W-1:0]   piles;        // saturated pile count latched at start
  logic                ten_deal;     // fifty cards plus two temp cells
  logic                plus_one;     // game number from 2^32 up
  logic                high_bit;     // game number from 2^31 up to 2^32-1
  logic [SEED_W-1:0]   lcg_seed;
  logic [CARD_W-1:0]   cards_left;
  logic [ROW_W-1:0]    deal_index;
  logic [PILE_W-1:0]   pile_cnt;
  logic [ROW_W-1:0]    row_cnt;

  // serial remainder unit
  logic [DRAW_W-1:0]   dvd;
  logic [CARD_W-1:0]   rem;
  logic [BITCNT_W-1:0] bit_cnt;
  logic [CARD_W:0]     rem_shift;
  logic                rem_ge;

  // deck memory with per-entry valid bits; an invalid entry reads as its slot + 1
  logic [CARD_W-1:0]   deck_mem [DECK_SIZE];
  logic [DECK_SIZE-1:0] deck_vld;
  logic [ADDR_W-1:0]   rd_addr;
  logic [ADDR_W-1:0]   rd_addr_q;
  logic [CARD_W-1:0]   rd_data_q;
  logic                rd_vld_q;
  logic [CARD_W-1:0]   rd_card;
  logic [CARD_W-1:0]   card_q;      // card picked at slot j
  logic [ADDR_W-1:0]   j_q;

  logic [SEED_W-1:0]   seed_next;
  logic [PILE_W-1:0]   piles_sat;

  assign busy = (state != S_IDLE);

  // lcg step: one 32x18 product per card
  assign seed_next = SEED_W'(lcg_seed * LCG_MUL) + LCG_INC;

  // pile count clamp: zero means one, above max saturates
  always_comb begin
    if (num_piles == '0) begin
      piles_sat = 4'd1;
    end else if (num_piles > PILES_MAX) begin
      piles_sat = PILES_MAX;
    end else begin
      piles_sat = num_piles;
    end
  end

  // remainder step: shift in one dividend bit, subtract if it fits
  assign rem_shift = {rem, dvd[DRAW_W-1]};
  assign rem_ge    = (rem_shift >= {1'b0, cards_left});

  // read address per state
  always_comb begin
    case (state)
      S_RDJ:   rd_addr = rem;
      S_RDL:   rd_addr = cards_left - 6'd1;
      S_T0:    rd_addr = 6'd1;
      S_T1:    rd_addr = 6'd0;
      default: rd_addr = rem;
    endcase
  end

  assign rd_card = rd_vld_q ? rd_data_q : (rd_addr_q + 6'd1);

  // deck memory, registered read
  always_ff @(posedge clk) begin
    rd_data_q <= deck_mem[rd_addr];
    rd_vld_q  <= deck_vld[rd_addr];
    rd_addr_q <= rd_addr;
    if (state == S_WR) begin
      deck_mem[j_q] <= rd_card;
    end
  end

  // valid bits: all cleared at deal start, set on each refill write
  always_ff @(posedge clk) begin
    if (rst) begin
      deck_vld <= '0;
    end else if (state == S_IDLE && start) begin
      deck_vld <= '0;
    end else if (state == S_WR) begin
      deck_vld[j_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_piles <= PILES_RESET;
    end else if (cfg_wr_en) begin
      num_piles <= cfg_wr_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      card_valid <= 1'b0;
    end else begin
      card_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_LCG;
          end
        end
        S_LCG: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (bit_cnt == DIV_LAST) begin
            state <= S_RDJ;
          end
        end
        S_RDJ: begin
          state <= S_RDL;
        end
        S_RDL: begin
          state <= S_WR;
        end
        S_WR: begin
          card_valid <= 1'b1;
          if (ten_deal && deal_index == TEN_LAST) begin
            state <= S_T0;
          end else if (deal_index == LAST_INDEX) begin
            state <= S_IDLE;
          end else begin
            state <= S_LCG;
          end
        end
        S_T0: begin
          state <= S_T1;
        end
        S_T1: begin
          card_valid <= 1'b1;
          state      <= S_T2;
        end
        S_T2: begin
          card_valid <= 1'b1;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          piles      <= piles_sat;
          ten_deal   <= (piles_sat == PILES_TEN);
          plus_one   <= game_number[GAME_W-1];
          high_bit   <= game_number[SEED_W-1];
          lcg_seed   <= game_number[SEED_W-1:0];
          cards_left <= DECK_FULL;
          deal_index <= '0;
          pile_cnt   <= '0;
          row_cnt    <= '0;
        end
      end
      S_LCG: begin
        lcg_seed <= seed_next;
        dvd      <= draw_value(seed_next, plus_one, high_bit);
        rem      <= '0;
        bit_cnt  <= '0;
      end
      S_DIV: begin
        rem     <= rem_ge ? CARD_W'(rem_shift - {1'b0, cards_left})
                          : rem_shift[CARD_W-1:0];
        dvd     <= {dvd[DRAW_W-2:0], 1'b0};
        bit_cnt <= bit_cnt + 5'd1;
      end
      S_RDJ: begin
        j_q <= rem;
      end
      S_RDL: begin
        card_q <= rd_card;
      end
      S_WR: begin
        // emit the picked card; slot j gets the deck's last card (write above)
        is_temp    <= 1'b0;
        pile       <= pile_cnt;
        row        <= row_cnt;
        suit       <= card_suit(card_q);
        rank       <= card_rank(card_q);
        last       <= (deal_index == LAST_INDEX);
        cards_left <= cards_left - 6'd1;
        deal_index <= deal_index + 6'd1;
        if (pile_cnt == piles - 4'd1) begin
          pile_cnt <= '0;
          row_cnt  <= row_cnt + 6'd1;
        end else begin
          pile_cnt <= pile_cnt + 4'd1;
        end
      end
      S_T1: begin
        // temp cell 0 takes slot 1
        is_temp <= 1'b1;
        pile    <= 4'd0;
        row     <= '0;
        suit    <= card_suit(rd_card);
        rank    <= card_rank(rd_card);
        last    <= 1'b0;
      end
      S_T2: begin
        // temp cell 1 takes slot 0, closing the deal
        is_temp <= 1'b1;
        pile    <= 4'd1;
        row     <= '0;
        suit    <= card_suit(rd_card);
        rank    <= card_rank(rd_card);
        last    <= 1'b1;
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTH
  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state)) else $error("sequencer state not one-hot");

  a_beat_in_deal: assert property (@(posedge clk) disable iff (rst)
    card_valid |-> $past(busy)) else $error("card beat outside a deal");

  a_last_ends_deal: assert property (@(posedge clk) disable iff (rst)
    (card_valid && last) |-> !busy) else $error("last beat while still dealing");

  a_rem_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RDJ) |-> (rem < cards_left)) else $error("pick index past deck end");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted game did not start");
`endif

endmodule

>>> sim/tb_lcg_shuffle_card_dealer.sv
// tb_lcg_shuffle_card_dealer: self-checking bench for the numbered solitaire deal generator
// depends on lcgdeal_pkg and lcg_shuffle_card_dealer; predicts every card beat in deal order
// and checks it field by field across directed deals, pile counts and random traffic
module tb_lcg_shuffle_card_dealer;
  timeunit 1ns;
  timeprecision 1ps;

  import lcgdeal_pkg::*;

  // generator constants, game number ranges and deal sizes
  localparam logic [31:0] LCG_A      = 32'd214013;
  localparam logic [31:0] LCG_C      = 32'd2531011;
  localparam int          FULL_DECK  = 52;
  localparam int          SHORT_DEAL = 50;
  localparam int          PILE_CAP   = 13;
  localparam int          TEN_PILES  = 10;
  localparam int          IDLE_LIMIT = 4000;   // cycles with no beat before giving up
  localparam int          DRAIN_WAIT = 64;     // wait after the last beat for a stray one

  localparam logic [32:0] GAME_MAX     = 33'h1_ffff_ffff;
  localparam logic [32:0] HIGH_BIT_MIN = 33'h0_8000_0000;
  localparam logic [32:0] PLUS_ONE_MIN = 33'h1_0000_0000;

  typedef enum logic [1:0] {
    DIAMOND = 2'd0,
    CLUB    = 2'd1,
    HEART   = 2'd2,
    SPADE   = 2'd3
  } suit_e;

  // one card beat as the block presents it
  typedef struct packed {
    logic              is_temp;
    logic [PILE_W-1:0] pile;
    logic [ROW_W-1:0]  row;
    logic [SUIT_W-1:0] suit;
    logic [RANK_W-1:0] rank;
    logic              last;
  } card_beat_t;

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic [PILE_W-1:0] cfg_wr_data;
  logic              start;
  logic [GAME_W-1:0] game_number;
  logic              busy;
  logic              card_valid;
  logic              is_temp;
  logic [PILE_W-1:0] pile;
  logic [ROW_W-1:0]  row;
  logic [SUIT_W-1:0] suit;
  logic [RANK_W-1:0] rank;
  logic              last;

  // bench copy of the pile count register and the queue of cards still to come
  logic [PILE_W-1:0] piles_setting;
  card_beat_t        expected_cards[$];
  int                errors;
  int                cards_seen;
  int                quiet_cycles;

  lcg_shuffle_card_dealer u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .start       (start),
    .game_number (game_number),
    .busy        (busy),
    .card_valid  (card_valid),
    .is_temp     (is_temp),
    .pile        (pile),
    .row         (row),
    .suit        (suit),
    .rank        (rank),
    .last        (last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // card value 1..52 into its beat fields; c mod 4 runs club, diamond, heart, spade
  function automatic card_beat_t make_card(input logic tmp, input int pile_i, input int row_i,
                                           input int card, input logic fin);
    card_beat_t b;
    int         c;
    c = card - 1;
    b.is_temp = tmp;
    b.pile    = PILE_W'(pile_i);
    b.row     = ROW_W'(row_i);
    case (c % 4)
      0:       b.suit = CLUB;
      1:       b.suit = DIAMOND;
      2:       b.suit = HEART;
      default: b.suit = SPADE;
    endcase
    b.rank = RANK_W'(c / 4 + 1);
    b.last = fin;
    return b;
  endfunction

  // shuffle one deck for this game number and queue every card in deal order
  function automatic void predict_deal(input logic [GAME_W-1:0] game);
    logic [CARD_W-1:0] deck [FULL_DECK];
    logic [31:0]       seed;
    logic [15:0]       r;
    int                draw_v;
    int                left;
    int                pick;
    int                idx;
    int                cols;
    int                to_deal;
    int                temp_slot;
    int                card;
    cols = int'(piles_setting);
    // zero piles acts as one, anything past the cap saturates
    if (cols == 0) cols = 1;
    if (cols > PILE_CAP) cols = PILE_CAP;
    // ten piles stops two cards short, the leftovers go to the temp cells
    to_deal = (cols == TEN_PILES) ? SHORT_DEAL : FULL_DECK;
    for (int k = 0; k < FULL_DECK; k++) deck[k] = CARD_W'(k + 1);
    left = FULL_DECK;
    seed = game[31:0];
    for (idx = 0; idx < to_deal; idx++) begin
      seed = seed * LCG_A + LCG_C;
      r    = seed[31:16];
      if (!game[32] && !game[31]) begin
        draw_v = int'(r[14:0]);
      end else if (!game[32]) begin
        draw_v = int'({1'b1, r[14:0]});    // bit 15 forced on
      end else begin
        draw_v = int'(r) + 1;              // can reach 2^16
      end
      pick = draw_v % left;
      card = int'(deck[pick]);
      left--;
      deck[pick] = deck[left];             // swap-remove from the tail
      expected_cards.push_back(make_card(1'b0, idx % cols, idx / cols, card,
                                         idx + 1 == FULL_DECK));
    end
    temp_slot = 0;
    while (left > 0) begin
      left--;
      expected_cards.push_back(make_card(1'b1, temp_slot, 0, int'(deck[left]), left == 0));
      temp_slot++;
    end
  endfunction

  // spread over the three game number ranges; every bit still toggles
  function automatic logic [GAME_W-1:0] random_game();
    logic [GAME_W-1:0] g;
    g = GAME_W'({$urandom(), $urandom()});
    case ($urandom_range(2))
      0:       g[32:31] = 2'b00;
      1:       g[32:31] = 2'b01;
      default: g[32]    = 1'b1;
    endcase
    return g;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: card %0d %s mismatch, expected %0d actual %0d",
               $time, cards_seen, name, want, got);
      errors++;
    end
  endfunction

  // result side: every strobed card is matched against the oldest prediction
  always @(posedge clk) begin
    card_beat_t want;
    if (!rst && card_valid) begin
      if (expected_cards.size() == 0) begin
        $display("%0t: unexpected card beat, expected none, %s %0d row %0d suit %0d rank %0d",
                 $time, "actual pile", pile, row, suit, rank);
        errors++;
      end else begin
        want = expected_cards.pop_front();
        check_field("is_temp", int'(want.is_temp), int'(is_temp));
        check_field("pile", int'(want.pile), int'(pile));
        check_field("row", int'(want.row), int'(row));
        check_field("suit", int'(want.suit), int'(suit));
        check_field("rank", int'(want.rank), int'(rank));
        check_field("last", int'(want.last), int'(last));
      end
      cards_seen++;
    end
  end

  // watchdog: any accepted game or card beat clears the count
  always @(posedge clk) begin
    if (rst || (start && !busy) || card_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, %0d cards still outstanding", $time, expected_cards.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // offer one game number, hold start until the block takes it
  task automatic send_deal(input logic [GAME_W-1:0] game, input int idle_pct);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    start       = 1'b1;
    game_number = game;
    do @(posedge clk); while (busy !== 1'b0);
    predict_deal(game);
    @(negedge clk);
    start       = 1'b0;
    game_number = random_game();           // ignored while start is low
  endtask

  // pile count write: only once the previous deal has fully drained
  task automatic set_piles(input logic [PILE_W-1:0] value);
    @(negedge clk);
    while (expected_cards.size() != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en     = 1'b1;
    cfg_wr_data   = value;
    piles_setting = value;
    @(negedge clk);
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = PILE_W'($urandom());
  endtask

  // reset value of eight piles, the classic deal numbers
  task automatic test_default_piles();
    send_deal(33'd1, 0);
    send_deal(33'd617, 0);
  endtask

  // edges of each seed range: plain 15-bit draw, forced bit 15, plus-one
  task automatic test_game_ranges();
    send_deal(33'd0, 0);
    send_deal(HIGH_BIT_MIN - 33'd1, 0);
    send_deal(HIGH_BIT_MIN, 0);
    send_deal(PLUS_ONE_MIN - 33'd1, 0);
    send_deal(PLUS_ONE_MIN, 0);
    send_deal(GAME_MAX, 0);
    send_deal(33'd11982, 0);
    send_deal(33'h1_5555_aaaa, 0);
  endtask

  // zero piles, one pile, the cap, the values past it and seven
  task automatic test_pile_extremes();
    logic [PILE_W-1:0] counts [6];
    counts = '{4'd0, 4'd1, 4'd13, 4'd14, 4'd15, 4'd7};
    foreach (counts[i]) begin
      set_piles(counts[i]);
      send_deal(random_game(), 0);
    end
  endtask

  // ten piles: fifty dealt cards, then temp cells 0 and 1
  task automatic test_ten_piles();
    set_piles(4'd10);
    send_deal(33'd1, 0);
    send_deal(HIGH_BIT_MIN + 33'd5, 0);
    send_deal(GAME_MAX, 0);
  endtask

  // random games in phases of sender idling, new pile count per phase
  task automatic test_random_deals();
    int idle_plan [6];
    logic [PILE_W-1:0] cols;
    idle_plan = '{0, 69, 12, 0, 69, 12};
    foreach (idle_plan[ph]) begin
      cols = PILE_W'($urandom_range(15));
      if (ph == 1) cols = 4'd10;
      set_piles(cols);
      repeat (50) send_deal(random_game(), idle_plan[ph]);
    end
  endtask

  initial begin
    errors        = 0;
    cards_seen    = 0;
    quiet_cycles  = 0;
    piles_setting = 4'd8;
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    start         = 1'b0;
    game_number   = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_default_piles();
    test_game_ranges();
    test_pile_extremes();
    test_ten_piles();
    test_random_deals();

    // drain, then give a stray beat time to show up
    while (expected_cards.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
